// ----- src/rbt_pkg.sv -----
// Shared types and constants for the rigid body transform unit.
`timescale 1ns / 1ps
package rbt_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_XX = 3'd0;
  localparam logic [2:0] CFG_XY = 3'd1;
  localparam logic [2:0] CFG_XZ = 3'd2;
  localparam logic [2:0] CFG_YY = 3'd3;
  localparam logic [2:0] CFG_YZ = 3'd4;
  localparam logic [2:0] CFG_ZZ = 3'd5;

  localparam logic [1:0] ROW_LAST = 2'd2;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef logic signed [17:0] rot_t;
  typedef rot_t [8:0] rot_mat_t;          // entry r*3+c holds R[r][c]
  typedef logic [5:0][31:0] inertia_t;   // xx, xy, xz, yy, yz, zz

  typedef struct packed {
    rot_mat_t         rot;
    logic [2:0][31:0] pos;              // [0] x, [1] y, [2] z
  } entry_t;

endpackage

// ----- src/rbt_front.sv -----
// Front end: quaternion products and rounded, saturated rotation matrix.
`timescale 1ns / 1ps
module rbt_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic signed [15:0]  quat_r,
  input  logic signed [15:0]  quat_i,
  input  logic signed [15:0]  quat_j,
  input  logic signed [15:0]  quat_k,
  input  logic signed [31:0]  pos_x,
  input  logic signed [31:0]  pos_y,
  input  logic signed [31:0]  pos_z,
  output logic                push,
  output rbt_pkg::entry_t     entry,
  output logic [1:0]          pending
);
  import rbt_pkg::*;

  localparam logic signed [34:0] ONE = 35'sd268435456;  // 1.0 in Q.28

  function automatic rot_t rot_round(input logic signed [34:0] raw);
    logic signed [34:0] s;
    logic signed [20:0] q;
    s = raw + 35'sd8192;
    q = s[34:14];
    if (q[20:17] == {4{q[17]}}) begin
      rot_round = q[17:0];
    end else if (q[20]) begin
      rot_round = 18'sh20000;
    end else begin
      rot_round = 18'sh1ffff;
    end
  endfunction

  logic v1, v2;
  logic signed [31:0] p_ri, p_rj, p_rk, p_ii, p_ij, p_ik, p_jj, p_jk, p_kk;
  logic [2:0][31:0] pos1;
  logic signed [34:0] e_ri, e_rj, e_rk, e_ii, e_ij, e_ik, e_jj, e_jk, e_kk;
  rot_mat_t rot_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= take;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      p_ri <= quat_r * quat_i;
      p_rj <= quat_r * quat_j;
      p_rk <= quat_r * quat_k;
      p_ii <= quat_i * quat_i;
      p_ij <= quat_i * quat_j;
      p_ik <= quat_i * quat_k;
      p_jj <= quat_j * quat_j;
      p_jk <= quat_j * quat_k;
      p_kk <= quat_k * quat_k;
      pos1 <= {pos_z, pos_y, pos_x};
    end
  end

  always_comb begin
    e_ri = p_ri; e_rj = p_rj; e_rk = p_rk;
    e_ii = p_ii; e_ij = p_ij; e_ik = p_ik;
    e_jj = p_jj; e_jk = p_jk; e_kk = p_kk;
    rot_next[0] = rot_round(ONE - (e_jj <<< 1) - (e_kk <<< 1));
    rot_next[1] = rot_round((e_ij <<< 1) - (e_rk <<< 1));
    rot_next[2] = rot_round((e_ik <<< 1) + (e_rj <<< 1));
    rot_next[3] = rot_round((e_ij <<< 1) + (e_rk <<< 1));
    rot_next[4] = rot_round(ONE - (e_ii <<< 1) - (e_kk <<< 1));
    rot_next[5] = rot_round((e_jk <<< 1) - (e_ri <<< 1));
    rot_next[6] = rot_round((e_ik <<< 1) - (e_rj <<< 1));
    rot_next[7] = rot_round((e_jk <<< 1) + (e_ri <<< 1));
    rot_next[8] = rot_round(ONE - (e_ii <<< 1) - (e_jj <<< 1));
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      entry.rot <= rot_next;
      entry.pos <= pos1;
    end
  end

  assign push    = v2;
  assign pending = {1'b0, v1} + {1'b0, v2};

endmodule

// ----- src/rbt_queue.sv -----
// Small queue of items between front and back.
`timescale 1ns / 1ps
module rbt_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  rbt_pkg::entry_t       wr_data,
  input  logic                  pop,
  output rbt_pkg::entry_t       rd_data,
  output logic                  not_empty,
  output logic [rbt_pkg::QAW:0] count
);
  import rbt_pkg::*;

  entry_t mem [QDEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_data;
  end

  assign rd_data   = mem[rd_ptr];
  assign not_empty = (count != '0);

endmodule

// ----- src/rbt_back.sv -----
// Back end: one matrix row per cycle, while an item is available, through T = R*I and W = T*R^T.
`timescale 1ns / 1ps
module rbt_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                avail,
  input  rbt_pkg::entry_t     head,
  input  rbt_pkg::inertia_t   inertia,
  output logic                pop,
  output logic                strobe,
  output logic [1:0]          row_index,
  output logic signed [17:0]  rot_c0,
  output logic signed [17:0]  rot_c1,
  output logic signed [17:0]  rot_c2,
  output logic signed [31:0]  translation,
  output logic signed [31:0]  world_c0,
  output logic signed [31:0]  world_c1,
  output logic signed [31:0]  world_c2,
  output logic                last_row
);
  import rbt_pkg::*;

  function automatic logic signed [31:0] body_at(input inertia_t in, input int k, input int c);
    logic signed [31:0] v;
    case (k * 3 + c)
      0:       v = in[CFG_XX];
      1, 3:    v = in[CFG_XY];
      2, 6:    v = in[CFG_XZ];
      4:       v = in[CFG_YY];
      5, 7:    v = in[CFG_YZ];
      8:       v = in[CFG_ZZ];
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [45:0] x);
    if (x[45:31] == {15{x[31]}}) return x[31:0];
    else if (x[45]) return 32'sh80000000;
    else return 32'sh7fffffff;
  endfunction

  logic [1:0] row;
  logic [3:0] base;
  rot_t       rrow [3];

  // stage A: products R[r][k] * I[k][c]
  logic               va;
  logic signed [49:0] pa [3][3];
  rot_mat_t           rot_a;
  logic [31:0]        pos_a;
  logic [1:0]         row_a;
  // stage B: T row
  logic               vb;
  logic signed [38:0] tb [3];
  rot_mat_t           rot_b;
  logic [31:0]        pos_b;
  logic [1:0]         row_b;
  // stage C: products T[k] * R[c][k]
  logic               vc;
  logic signed [56:0] pc [3][3];
  rot_t               rrow_c [3];
  logic [31:0]        pos_c;
  logic [1:0]         row_c;

  logic signed [52:0] acc_t [3];
  logic signed [59:0] acc_w [3];

  assign pop  = avail && (row == ROW_LAST);
  assign base = (row == 2'd0) ? 4'd0 : ((row == 2'd1) ? 4'd3 : 4'd6);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rrow[k] = head.rot[base + 4'(k)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      va  <= 1'b0;
      vb  <= 1'b0;
      vc  <= 1'b0;
      strobe <= 1'b0;
    end else begin
      if (avail) row <= (row == ROW_LAST) ? 2'd0 : row + 2'd1;
      va <= avail;
      vb <= va;
      vc <= vb;
      strobe <= vc;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      for (int c = 0; c < 3; c++) begin
        pa[k][c] <= rrow[k] * body_at(inertia, k, c);
      end
    end
    rot_a <= head.rot;
    pos_a <= head.pos[row];
    row_a <= row;
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc_t[c] = pa[0][c] + pa[1][c] + pa[2][c] + 53'sd8192;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      tb[c] <= acc_t[c][52:14];
    end
    rot_b <= rot_a;
    pos_b <= pos_a;
    row_b <= row_a;
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 3; k++) begin
        pc[c][k] <= tb[k] * rot_b[c*3 + k];
      end
      rrow_c[c] <= rot_b[32'(row_b) * 3 + c];
    end
    pos_c <= pos_b;
    row_c <= row_b;
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc_w[c] = pc[c][0] + pc[c][1] + pc[c][2] + 60'sd8192;
    end
  end

  always_ff @(posedge clk) begin
    row_index   <= row_c;
    rot_c0      <= rrow_c[0];
    rot_c1      <= rrow_c[1];
    rot_c2      <= rrow_c[2];
    translation <= pos_c;
    world_c0    <= sat32(acc_w[0][59:14]);
    world_c1    <= sat32(acc_w[1][59:14]);
    world_c2    <= sat32(acc_w[2][59:14]);
    last_row    <= (row_c == ROW_LAST);
  end

endmodule

// ----- src/rigid_body_transform_and_world_inertia_unit.sv -----
// Top level: rigid body transform and world inverse inertia unit.
//
//   channel   handshake               payload
//   -------   ---------------------   -------------------------------------------
//   input     start / busy            quat_r..quat_k (Q1.14), pos_x..pos_z
//   result    strobe (one cycle)      row_index, rot_c0..c2, translation,
//                                     world_c0..c2, last_row
//   config    cfg_write               cfg_index, cfg_data (inertia registers)
//
// Each item yields three row items on consecutive cycles; the back end
// turns out one row per cycle while the queue holds an item. The first row
// reaches the ports through 2 front registers, the queue write, 3 back
// stages and the output register.
// rst is synchronous and clears pipeline valids, queue and the inertia
// registers. The receiver cannot stall; busy rises only when front plus
// queue hold QDEPTH items.
`timescale 1ns / 1ps
module rigid_body_transform_and_world_inertia_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic signed [15:0]  quat_r,
  input  logic signed [15:0]  quat_i,
  input  logic signed [15:0]  quat_j,
  input  logic signed [15:0]  quat_k,
  input  logic signed [31:0]  pos_x,
  input  logic signed [31:0]  pos_y,
  input  logic signed [31:0]  pos_z,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  output logic                strobe,
  output logic [1:0]          row_index,
  output logic signed [17:0]  rot_c0,
  output logic signed [17:0]  rot_c1,
  output logic signed [17:0]  rot_c2,
  output logic signed [31:0]  translation,
  output logic signed [31:0]  world_c0,
  output logic signed [31:0]  world_c1,
  output logic signed [31:0]  world_c2,
  output logic                last_row
);
  import rbt_pkg::*;

  inertia_t       inertia;
  logic           take;
  logic           push, pop, not_empty;
  entry_t         fe_entry, head;
  logic [1:0]     pending;
  logic [QAW:0]   q_count;
  logic [QAW+1:0] inflight;

  // body inverse inertia registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      inertia <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_XX:  inertia[CFG_XX] <= cfg_data;
        CFG_XY:  inertia[CFG_XY] <= cfg_data;
        CFG_XZ:  inertia[CFG_XZ] <= cfg_data;
        CFG_YY:  inertia[CFG_YY] <= cfg_data;
        CFG_YZ:  inertia[CFG_YZ] <= cfg_data;
        CFG_ZZ:  inertia[CFG_ZZ] <= cfg_data;
        default: ;
      endcase
    end
  end

  // every item in the front stages has a queue slot reserved
  assign inflight = (QAW+2)'(pending) + (QAW+2)'(q_count);
  assign busy     = (inflight >= (QAW+2)'(QDEPTH));
  assign take     = start && !busy;

  rbt_front u_front (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .quat_r  (quat_r),
    .quat_i  (quat_i),
    .quat_j  (quat_j),
    .quat_k  (quat_k),
    .pos_x   (pos_x),
    .pos_y   (pos_y),
    .pos_z   (pos_z),
    .push    (push),
    .entry   (fe_entry),
    .pending (pending)
  );

  rbt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_data   (fe_entry),
    .pop       (pop),
    .rd_data   (head),
    .not_empty (not_empty),
    .count     (q_count)
  );

  rbt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .avail       (not_empty),
    .head        (head),
    .inertia     (inertia),
    .pop         (pop),
    .strobe      (strobe),
    .row_index   (row_index),
    .rot_c0      (rot_c0),
    .rot_c1      (rot_c1),
    .rot_c2      (rot_c2),
    .translation (translation),
    .world_c0    (world_c0),
    .world_c1    (world_c1),
    .world_c2    (world_c2),
    .last_row    (last_row)
  );

endmodule

// ----- dv/tb_rigid_body_transform_and_world_inertia_unit.sv -----
// Testbench for the rigid body transform and world inverse inertia unit.
`timescale 1ns / 1ps

// One row item as predicted or as seen on the result ports.
typedef struct {
  longint row;
  longint rot[3];
  longint trans;
  longint world[3];
  longint last;
} row_t;

// Predicts the three row items of each accepted item and checks the rows that come out.
class row_scoreboard;
  row_t   pending_rows[$];
  longint inertia[6];
  int     errors;
  int     rows_seen;

  function new();
    errors    = 0;
    rows_seen = 0;
    foreach (inertia[n]) inertia[n] = 0;
  endfunction

  // Indexes past the last register are dropped by the block.
  function void write_inertia(int idx, logic [31:0] data);
    if (idx < 6) inertia[idx] = longint'($signed(data));
  endfunction

  // round to Q.14 less, ties toward plus infinity (arithmetic shift floors)
  function longint round_q14(longint x);
    longint y;
    y = x + 64'sd8192;
    return y >>> 14;
  endfunction

  function longint clamp(longint x, longint lo, longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  function void note_item(logic signed [15:0] qr_in, logic signed [15:0] qi_in,
                          logic signed [15:0] qj_in, logic signed [15:0] qk_in,
                          logic signed [31:0] px, logic signed [31:0] py,
                          logic signed [31:0] pz);
    longint qr, qi, qj, qk, one, acc;
    longint raw[3][3], rot[3][3], body[3][3], t[3][3], w[3][3], pos[3];
    row_t   rw;
    qr = qr_in; qi = qi_in; qj = qj_in; qk = qk_in;
    pos[0] = px; pos[1] = py; pos[2] = pz;
    one = 64'sd1 <<< 28;
    raw[0][0] = one - 2 * qj * qj - 2 * qk * qk;
    raw[0][1] = 2 * qi * qj - 2 * qr * qk;
    raw[0][2] = 2 * qi * qk + 2 * qr * qj;
    raw[1][0] = 2 * qi * qj + 2 * qr * qk;
    raw[1][1] = one - 2 * qi * qi - 2 * qk * qk;
    raw[1][2] = 2 * qj * qk - 2 * qr * qi;
    raw[2][0] = 2 * qi * qk - 2 * qr * qj;
    raw[2][1] = 2 * qj * qk + 2 * qr * qi;
    raw[2][2] = one - 2 * qi * qi - 2 * qj * qj;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        rot[r][c] = clamp(round_q14(raw[r][c]), -131072, 131071);
    body[0][0] = inertia[0];
    body[0][1] = inertia[1]; body[1][0] = inertia[1];
    body[0][2] = inertia[2]; body[2][0] = inertia[2];
    body[1][1] = inertia[3];
    body[1][2] = inertia[4]; body[2][1] = inertia[4];
    body[2][2] = inertia[5];
    // T = R*I kept at full width, then W = T*R^T saturated
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += rot[r][k] * body[k][c];
        t[r][c] = round_q14(acc);
      end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += t[r][k] * rot[c][k];
        w[r][c] = clamp(round_q14(acc), -64'sd2147483648, 64'sd2147483647);
      end
    for (int r = 0; r < 3; r++) begin
      rw.row   = r;
      rw.trans = pos[r];
      rw.last  = (r == 2);
      for (int c = 0; c < 3; c++) begin
        rw.rot[c]   = rot[r][c];
        rw.world[c] = w[r][c];
      end
      pending_rows.push_back(rw);
    end
  endfunction

  function void cmp(string name, longint exp_v, longint act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
    end
  endfunction

  function void check_row(row_t act);
    row_t exp_r;
    rows_seen++;
    if (pending_rows.size() == 0) begin
      errors++;
      $display("%0t: unexpected row item, expected none actual row %0d", $time, act.row);
      return;
    end
    exp_r = pending_rows.pop_front();
    cmp("row_index", exp_r.row, act.row);
    cmp("rot_c0", exp_r.rot[0], act.rot[0]);
    cmp("rot_c1", exp_r.rot[1], act.rot[1]);
    cmp("rot_c2", exp_r.rot[2], act.rot[2]);
    cmp("translation", exp_r.trans, act.trans);
    cmp("world_c0", exp_r.world[0], act.world[0]);
    cmp("world_c1", exp_r.world[1], act.world[1]);
    cmp("world_c2", exp_r.world[2], act.world[2]);
    cmp("last_row", exp_r.last, act.last);
  endfunction
endclass

module tb_rigid_body_transform_and_world_inertia_unit;
  import rbt_pkg::*;

  logic               clk, rst, start, busy;
  logic signed [15:0] quat_r, quat_i, quat_j, quat_k;
  logic signed [31:0] pos_x, pos_y, pos_z;
  logic               cfg_write;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               strobe, last_row;
  logic [1:0]         row_index;
  logic signed [17:0] rot_c0, rot_c1, rot_c2;
  logic signed [31:0] translation, world_c0, world_c1, world_c2;

  row_scoreboard sb;
  int idle_pct;     // chance in a hundred that the sender idles after an item
  int items_sent;

  rigid_body_transform_and_world_inertia_unit dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Row items cannot be held off, so every strobe is checked at the edge that ends it.
  always @(posedge clk) begin
    row_t act;
    if (!rst && strobe) begin
      act.row      = row_index;
      act.rot[0]   = rot_c0;
      act.rot[1]   = rot_c1;
      act.rot[2]   = rot_c2;
      act.trans    = translation;
      act.world[0] = world_c0;
      act.world[1] = world_c1;
      act.world[2] = world_c2;
      act.last     = last_row;
      sb.check_row(act);
    end
  end

  // Called at a falling edge; returns at the falling edge after the take or its idle gap.
  // start stays high across back-to-back items and only drops for an idle gap.
  task automatic send_item(logic [15:0] r, logic [15:0] i, logic [15:0] j,
                           logic [15:0] k, logic [31:0] x, logic [31:0] y,
                           logic [31:0] z);
    bit taken;
    quat_r = r; quat_i = i; quat_j = j; quat_k = k;
    pos_x = x; pos_y = y; pos_z = z;
    start = 1'b1;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      if (!busy) taken = 1'b1;
    end
    sb.note_item(r, i, j, k, x, y, z);
    items_sent++;
    @(negedge clk);
    if ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  // Sender holds off until every expected row has arrived or the guard runs out, then idles.
  task automatic drain();
    int guard;
    start = 1'b0;
    guard = 0;
    while (sb.pending_rows.size() != 0 && guard < 5000) begin
      @(negedge clk);
      guard++;
    end
    repeat (12) @(negedge clk);
  endtask

  // Register writes happen only with the block drained.
  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_write = 1'b0;
    sb.write_inertia(idx, data);
  endtask

  task automatic load_tensor(logic [31:0] xx, logic [31:0] xy, logic [31:0] xz,
                             logic [31:0] yy, logic [31:0] yz, logic [31:0] zz);
    drain();
    write_reg(CFG_XX, xx);
    write_reg(CFG_XY, xy);
    write_reg(CFG_XZ, xz);
    write_reg(CFG_YY, yy);
    write_reg(CFG_YZ, yz);
    write_reg(CFG_ZZ, zz);
  endtask

  // Components mostly within plus or minus 1.0, else full field range; some identities.
  task automatic random_items(int count);
    logic [15:0] q[4];
    for (int n = 0; n < count; n++) begin
      for (int m = 0; m < 4; m++)
        q[m] = ($urandom_range(99) < 65) ? 16'($signed($urandom_range(0, 32768)) - 16384)
                                         : 16'($urandom);
      if ($urandom_range(9) == 0) q = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0};
      send_item(q[0], q[1], q[2], q[3], $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    sb = new();
    items_sent = 0;
    idle_pct = 15;
    rst = 1'b1;
    start = 1'b0;
    quat_r = '0; quat_i = '0; quat_j = '0; quat_k = '0;
    pos_x = '0; pos_y = '0; pos_z = '0;
    cfg_write = 1'b0; cfg_index = '0; cfg_data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: tensor still at reset (all zero).
    send_item(16'sd16384, 0, 0, 0, 32'h7fffffff, 32'h80000000, 0);
    send_item(0, 0, 0, 0, 32'hffffffff, 1, 32'h00010000);
    // Unit tensor on the diagonal, identity, quarter turns and a half turn.
    load_tensor(32'h00010000, 0, 0, 32'h00010000, 0, 32'h00010000);
    send_item(16'sd16384, 0, 0, 0, 0, 0, 0);
    send_item(16'sd11585, 16'sd11585, 0, 0, 1, 2, 3);
    send_item(16'sd11585, 0, 16'sd11585, 0, -1, -2, -3);
    send_item(16'sd11585, 0, 0, 16'sd11585, 32'h12345678, 32'h9abcdef0, 32'h0f0f0f0f);
    send_item(0, 0, 0, 16'sd16384, 0, 0, 0);
    // Unnormalized extremes: rotation entries saturate both ways.
    send_item(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_item(16'h8000, 16'h8000, 16'h8000, 16'h8000, 32'h80000000, 32'h80000000, 32'h80000000);
    send_item(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 0, 0, 0);
    send_item(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 1, 1, 1);
    send_item(0, 16'h8000, 0, 0, 0, 0, 0);
    // Largest positive tensor: world entries saturate.
    load_tensor(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_item(16'sd16384, 0, 0, 0, 0, 0, 0);
    send_item(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 0, 0, 0);
    send_item(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192, 0, 0, 0);
    // Most negative tensor, plus writes to the unused indexes, which must be ignored.
    load_tensor(32'h80000000, 32'h80000000, 32'h80000000,
                32'h80000000, 32'h80000000, 32'h80000000);
    write_reg(3'd6, 32'h00010000);
    write_reg(3'd7, 32'hdeadbeef);
    send_item(16'sd16384, 0, 0, 0, 0, 0, 0);
    send_item(16'h8000, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0);
    send_item(16'sd11585, 16'sd11585, 0, 0, 0, 0, 0);

    // Random phase one: light sender idling, mixed tensor.
    load_tensor(32'h00020000, 32'hffff8000, 32'h00004000,
                32'h00010000, 32'h00001000, 32'h00030000);
    idle_pct = 15;
    random_items(50);
    // Phase two: heavy idling with a fully random tensor.
    load_tensor($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    idle_pct = 82;
    random_items(50);
    // Phase three: back to back, small random tensor.
    load_tensor($urandom_range(0, 32'h3ffff), $urandom_range(0, 32'hffff),
                $urandom_range(0, 32'hffff), $urandom_range(0, 32'h3ffff),
                $urandom_range(0, 32'hffff), $urandom_range(0, 32'h3ffff));
    idle_pct = 0;
    random_items(52);

    drain();
    if (sb.pending_rows.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d row items never arrived, expected 0 left actual %0d",
               $time, sb.pending_rows.size(), sb.pending_rows.size());
    end
    $display("Ran %0d items (%0d row items checked) over seven tensor settings,",
             items_sent, sb.rows_seen);
    $display("with saturating quaternions, ignored register indexes and three idling profiles.");
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
